FILE: rtl/tzc3_pkg.sv
// ----------------------------------------------------------------------------
// tzc3_pkg
// Types, zone codes and calendar helpers for the UTC+3 time zone converter.
// ----------------------------------------------------------------------------
package tzc3_pkg;

  localparam int unsigned InTdataW  = 56;  // 54 field bits, padded to bytes
  localparam int unsigned InTuserW  = 3;
  localparam int unsigned OutTdataW = 48;  // 43 field bits, padded to bytes

  localparam logic [2:0]  WeekdayMax   = 3'd6;
  localparam logic [3:0]  MonthMin     = 4'd1;
  localparam logic [3:0]  MonthMax     = 4'd12;
  localparam logic [3:0]  MonthFeb     = 4'd2;
  localparam logic [13:0] YearMax      = 14'd9999;
  localparam logic [13:0] YearBase     = 14'd1900;
  localparam logic [4:0]  HourMax      = 5'd23;
  localparam logic [5:0]  MinSecMax    = 6'd59;
  localparam logic [3:0]  OffsetHrMax  = 4'd14;
  localparam logic [4:0]  DaysLong     = 5'd31;
  localparam logic [4:0]  DaysShort    = 5'd30;
  localparam logic [4:0]  DaysFebLeap  = 5'd29;
  localparam logic [4:0]  DaysFeb      = 5'd28;

  // Source zone selector
  typedef enum logic [2:0] {
    ZONE_UT      = 3'd0,
    ZONE_GMT     = 3'd1,
    ZONE_EDT     = 3'd2,
    ZONE_CDT     = 3'd3,
    ZONE_MDT     = 3'd4,
    ZONE_PDT     = 3'd5,
    ZONE_NUMERIC = 3'd6,
    ZONE_NUM_ALT = 3'd7
  } zone_e;

  typedef struct packed {
    logic [5:0]  offset_minutes;
    logic [3:0]  offset_hours;
    logic        offset_negative;
    zone_e       zone_code;
    logic [5:0]  second_in;
    logic [5:0]  minute_in;
    logic [4:0]  hour_in;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [2:0]  weekday_in;
  } item_t;

  typedef struct packed {
    logic [5:0]  second_out;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [2:0]  weekday_out;
  } result_t;

  // Gregorian leap rule. y % 25 via reciprocal multiply: floor(y*5243/2^17)
  // equals floor(y/25) for every 14-bit y.
  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic [10:0] quo;
    logic [13:0] rem;
    logic        div4;
    logic        div16;
    logic        div25;
    prod  = 28'(y) * 28'd5243;
    quo   = prod[27:17];
    rem   = y - 14'({3'b000, quo} * 14'd25);
    div4  = (y[1:0] == 2'b00);
    div16 = (y[3:0] == 4'b0000);
    div25 = (rem == 14'd0);
    if (div4 && div25) begin
      return div16;
    end
    return div4;
  endfunction

  // Month 0 (December of the year before) reads as 31 days
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = DaysLong;
    if (m == MonthFeb) begin
      len = leap ? DaysFebLeap : DaysFeb;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = DaysShort;
    end
    return len;
  endfunction

  function automatic logic [3:0] named_shift(input zone_e z);
    logic [3:0] sh;
    case (z)
      ZONE_UT, ZONE_GMT: sh = 4'd3;
      ZONE_EDT:          sh = 4'd7;
      ZONE_CDT:          sh = 4'd8;
      ZONE_MDT:          sh = 4'd9;
      ZONE_PDT:          sh = 4'd10;
      default:           sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

FILE: rtl/tzc3_convert.sv
// ----------------------------------------------------------------------------
// tzc3_convert
// Combinational conversion of one date/time item to UTC+3: clamp, shift,
// then single-step carry/borrow through minute, hour, day, month and year.
// ----------------------------------------------------------------------------
module tzc3_convert (
  input  tzc3_pkg::item_t   item_i,
  output tzc3_pkg::result_t result_o
);

  logic [2:0]        wd;
  logic [3:0]        mon;
  logic [13:0]       yr_sat;
  logic [13:0]       yr;
  logic [4:0]        hr;
  logic [5:0]        mi;
  logic [5:0]        se;
  logic [3:0]        oh;
  logic [5:0]        om;
  logic [4:0]        dy;
  logic              leap;
  logic [4:0]        len_cur;
  logic [4:0]        len_prev;
  logic signed [7:0] hr_s;
  logic signed [7:0] mi_s;
  logic [5:0]        dy_w;
  logic [2:0]        wd_o;
  logic [3:0]        mon_w;
  logic [4:0]        mon_o;
  logic [13:0]       yr_o;
  logic              day_back;
  logic              day_fwd;

  always_comb begin
    // clamp fields into range
    wd     = (item_i.weekday_in > tzc3_pkg::WeekdayMax) ? tzc3_pkg::WeekdayMax
                                                       : item_i.weekday_in;
    mon    = (item_i.month_in > tzc3_pkg::MonthMax) ? tzc3_pkg::MonthMax
                                                    : item_i.month_in;
    if (mon < tzc3_pkg::MonthMin) begin
      mon = tzc3_pkg::MonthMin;
    end
    yr_sat = (item_i.year_in > tzc3_pkg::YearMax) ? tzc3_pkg::YearMax : item_i.year_in;
    yr     = (yr_sat < tzc3_pkg::YearBase) ? yr_sat + tzc3_pkg::YearBase : yr_sat;
    hr     = (item_i.hour_in > tzc3_pkg::HourMax) ? tzc3_pkg::HourMax : item_i.hour_in;
    mi     = (item_i.minute_in > tzc3_pkg::MinSecMax) ? tzc3_pkg::MinSecMax
                                                      : item_i.minute_in;
    se     = (item_i.second_in > tzc3_pkg::MinSecMax) ? tzc3_pkg::MinSecMax
                                                      : item_i.second_in;
    oh     = (item_i.offset_hours > tzc3_pkg::OffsetHrMax) ? tzc3_pkg::OffsetHrMax
                                                           : item_i.offset_hours;
    om     = (item_i.offset_minutes > tzc3_pkg::MinSecMax) ? tzc3_pkg::MinSecMax
                                                           : item_i.offset_minutes;

    leap     = tzc3_pkg::is_leap(yr);
    len_cur  = tzc3_pkg::month_len(mon, leap);
    len_prev = tzc3_pkg::month_len(mon - 4'd1, leap);
    dy       = (item_i.day_in == 5'd0) ? 5'd1 : item_i.day_in;
    if (dy > len_cur) begin
      dy = len_cur;
    end

    // zone shift
    case (item_i.zone_code)
      tzc3_pkg::ZONE_NUMERIC, tzc3_pkg::ZONE_NUM_ALT: begin
        if (item_i.offset_negative) begin
          hr_s = $signed({3'b000, hr}) + $signed({4'b0000, oh}) + 8'sd3;
          mi_s = $signed({2'b00, mi}) + $signed({2'b00, om});
        end else begin
          hr_s = $signed({3'b000, hr}) + 8'sd3 - $signed({4'b0000, oh});
          mi_s = $signed({2'b00, mi}) - $signed({2'b00, om});
        end
      end
      default: begin
        hr_s = $signed({3'b000, hr}) + $signed({4'b0000, tzc3_pkg::named_shift(item_i.zone_code)});
        mi_s = $signed({2'b00, mi});
      end
    endcase

    if (mi_s < 8'sd0) begin
      mi_s = mi_s + 8'sd60;
      hr_s = hr_s - 8'sd1;
    end else if (mi_s >= 8'sd60) begin
      mi_s = mi_s - 8'sd60;
      hr_s = hr_s + 8'sd1;
    end

    day_back = 1'b0;
    day_fwd  = 1'b0;
    wd_o     = wd;
    if (hr_s < 8'sd0) begin
      hr_s     = hr_s + 8'sd24;
      wd_o     = (wd == 3'd0) ? tzc3_pkg::WeekdayMax : wd - 3'd1;
      day_back = 1'b1;
    end else if (hr_s >= 8'sd24) begin
      hr_s     = hr_s - 8'sd24;
      wd_o     = (wd == tzc3_pkg::WeekdayMax) ? 3'd0 : wd + 3'd1;
      day_fwd  = 1'b1;
    end

    // day and month roll; month kept one bit wider for the step up
    dy_w  = {1'b0, dy};
    mon_o = {1'b0, mon};
    if (day_back) begin
      if (dy == 5'd1) begin
        dy_w  = {1'b0, len_prev};
        mon_o = {1'b0, mon} - 5'd1;
      end else begin
        dy_w  = {1'b0, dy} - 6'd1;
      end
    end else if (day_fwd) begin
      if (dy == len_cur) begin
        dy_w  = 6'd1;
        mon_o = {1'b0, mon} + 5'd1;
      end else begin
        dy_w  = {1'b0, dy} + 6'd1;
      end
    end

    yr_o  = yr;
    mon_w = mon_o[3:0];
    if (mon_o == 5'd0) begin
      mon_w = tzc3_pkg::MonthMax;
      yr_o  = yr - 14'd1;
    end else if (mon_o > {1'b0, tzc3_pkg::MonthMax}) begin
      mon_w = tzc3_pkg::MonthMin;
      yr_o  = yr + 14'd1;
    end

    result_o.weekday_out = wd_o;
    result_o.day_out     = dy_w[4:0];
    result_o.month_out   = mon_w;
    result_o.year_out    = yr_o;
    result_o.hour_out    = hr_s[4:0];
    result_o.minute_out  = mi_s[5:0];
    result_o.second_out  = se;
  end

endmodule

FILE: rtl/time_zone_to_utc_plus3_convert.sv
// ----------------------------------------------------------------------------
// time_zone_to_utc_plus3_convert
// Stream converter of a broken-down local date/time in a source zone to UTC+3.
// ----------------------------------------------------------------------------
// Datapath: input register, conversion logic, result register, in that order.
// Throughput: one transaction per cycle unless m_axis_tready stalls; set by
//   the single-pass conversion logic between the two registers.
// Reset: rst_ni clears both valid flags; no payload is reset.
module time_zone_to_utc_plus3_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // weekday_in[2:0], day_in[7:3], month_in[11:8], year_in[25:12],
  // hour_in[30:26], minute_in[36:31], second_in[42:37], offset_negative[43],
  // offset_hours[47:44], offset_minutes[53:48], zero pad[55:54]
  input  logic [tzc3_pkg::InTdataW-1:0]  s_axis_tdata,
  // zone_code[2:0]
  input  logic [tzc3_pkg::InTuserW-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // weekday_out[2:0], day_out[7:3], month_out[11:8], year_out[25:12],
  // hour_out[30:26], minute_out[36:31], second_out[42:37], zero pad[47:43]
  output logic [tzc3_pkg::OutTdataW-1:0] m_axis_tdata
);

  tzc3_pkg::item_t   in_d;
  tzc3_pkg::item_t   in_q;
  logic              in_vld_q;
  tzc3_pkg::result_t res_d;
  tzc3_pkg::result_t res_q;
  logic              res_vld_q;
  logic              res_free;
  logic              in_free;

  assign res_free      = !res_vld_q || m_axis_tready;
  assign in_free       = !in_vld_q || res_free;
  assign s_axis_tready = in_free;

  always_comb begin
    in_d.weekday_in      = s_axis_tdata[2:0];
    in_d.day_in          = s_axis_tdata[7:3];
    in_d.month_in        = s_axis_tdata[11:8];
    in_d.year_in         = s_axis_tdata[25:12];
    in_d.hour_in         = s_axis_tdata[30:26];
    in_d.minute_in       = s_axis_tdata[36:31];
    in_d.second_in       = s_axis_tdata[42:37];
    in_d.offset_negative = s_axis_tdata[43];
    in_d.offset_hours    = s_axis_tdata[47:44];
    in_d.offset_minutes  = s_axis_tdata[53:48];
    in_d.zone_code       = tzc3_pkg::zone_e'(s_axis_tuser);
  end

  tzc3_convert u_convert (
    .item_i   (in_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (res_free) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid) begin
      in_q <= in_d;
    end
    if (res_free && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {5'b00000,
                          res_q.second_out,
                          res_q.minute_out,
                          res_q.hour_out,
                          res_q.year_out,
                          res_q.month_out,
                          res_q.day_out,
                          res_q.weekday_out};

endmodule
